/* hdl/tt_pkg.sv */
// tt_pkg: shared types and constants for the text terminal grid
// depends on nothing; imported by tt_cell, tt_grid, tt_chk and text_terminal_grid_top
package tt_pkg;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int CNT_W  = 32;

    localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BS = 8'd8;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // one grid update: optional scroll up and optional single cell write
    typedef struct packed {
        logic              scroll;
        logic              wr;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CHAR_W-1:0] data;
    } t_grid_cmd;

    // read side: load the row select stage, then pick the column
    typedef struct packed {
        logic             load;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_grid_rd;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_ROW  = 4'b0100,
        S_COL  = 4'b1000
    } t_state;

endpackage

/* hdl/text_terminal_grid_top.sv */
// text_terminal_grid_top: character terminal grid with cursor and counters
// depends on tt_pkg and tt_grid
//
//  channel   handshake            payload
//  -------   ------------------   --------------------------------------------
//  item in   start & !busy        i_action i_char_in i_read_row i_read_col
//  result    o_done, one cycle    o_cell_char o_read_valid o_cursor_row
//                                 o_cursor_col o_scrolled o_char_count
//                                 o_scroll_count
//  config    i_cfg_we             i_cfg_wdata (enabled)
//
// every item passes through these steps: decode and cursor update, grid update with
// row select, column select into the result registers, then the strobe cycle,
// in which the next word may already be accepted.
// a scroll moves every cell up in the grid update step; a cell written in that update takes the write.
// reset clears all cells at once; no clearing pass. results cannot be stalled.
module text_terminal_grid_top import tt_pkg::*; #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_action,
    input  logic [CHAR_W-1:0] i_char_in,
    input  logic [ROW_W-1:0]  i_read_row,
    input  logic [COL_W-1:0]  i_read_col,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    output logic              o_done,
    output logic [CHAR_W-1:0] o_cell_char,
    output logic              o_read_valid,
    output logic [ROW_W-1:0]  o_cursor_row,
    output logic [COL_W-1:0]  o_cursor_col,
    output logic              o_scrolled,
    output logic [CNT_W-1:0]  o_char_count,
    output logic [CNT_W-1:0]  o_scroll_count
);

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);

    t_state             r_state, n_state;
    logic               r_enabled;
    logic               r_action;
    logic [CHAR_W-1:0]  r_char;
    logic [ROW_W-1:0]   r_rd_row;
    logic [COL_W-1:0]   r_rd_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [CNT_W-1:0]   r_wcnt, n_wcnt;
    logic [CNT_W-1:0]   r_scnt, n_scnt;
    logic               r_scrolled, n_scr;
    t_grid_cmd          r_cmd, n_cmd;
    logic               r_done;
    logic [CHAR_W-1:0]  r_cell_char;
    logic               r_read_valid;
    logic               w_rd_ok;
    logic [CHAR_W-1:0]  w_grid_char;
    t_grid_rd           w_rd;

    // cursor and grid update for a put word while enabled; a CR changes nothing
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_wcnt = r_wcnt;
        n_scnt = r_scnt;
        n_scr  = 1'b0;
        n_cmd  = '0;
        if (r_state == S_EXEC && r_action == ACT_PUT && r_enabled && r_char != CH_CR) begin
            unique case (r_char)
                CH_LF: begin
                    n_col = '0;
                    if (r_row == LAST_ROW) begin
                        n_scr = 1'b1;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
                CH_BS: begin
                    if (r_col != '0) begin
                        n_col      = r_col - 1'b1;
                        n_cmd.wr   = 1'b1;
                        n_cmd.row  = r_row;
                        n_cmd.col  = n_col;
                        n_cmd.data = '0;
                    end
                end
                default: begin
                    // last column is never written: wrap first
                    if (r_col >= LAST_COL) begin
                        n_cmd.col = '0;
                        n_col     = COL_W'(1);
                        if (r_row == LAST_ROW) begin
                            n_scr = 1'b1;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end else begin
                        n_cmd.col = r_col;
                        n_col     = r_col + 1'b1;
                    end
                    n_cmd.wr   = 1'b1;
                    n_cmd.row  = n_row;
                    n_cmd.data = r_char;
                    n_wcnt     = r_wcnt + 1'b1;
                end
            endcase
            n_cmd.scroll = n_scr;
            if (n_scr) begin
                n_scnt = r_scnt + 1'b1;
            end
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = start ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_ROW;
            S_ROW:   n_state = S_COL;
            S_COL:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_enabled <= 1'b0;
            r_row     <= '0;
            r_col     <= '0;
            r_wcnt    <= '0;
            r_scnt    <= '0;
            r_cmd     <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_enabled <= i_cfg_wdata;
            end
            r_row  <= n_row;
            r_col  <= n_col;
            r_wcnt <= n_wcnt;
            r_scnt <= n_scnt;
            r_cmd  <= n_cmd;
            r_done <= (r_state == S_COL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_action <= i_action;
            r_char   <= i_char_in;
            r_rd_row <= i_read_row;
            r_rd_col <= i_read_col;
        end
        if (r_state == S_EXEC) begin
            r_scrolled <= n_scr;
        end
        if (r_state == S_COL) begin
            r_cell_char  <= w_rd_ok ? w_grid_char : '0;
            r_read_valid <= w_rd_ok;
        end
    end

    assign w_rd_ok = (r_action == ACT_READ)
                  && ({1'b0, r_rd_row} < (ROW_W + 1)'(ROWS))
                  && ({1'b0, r_rd_col} < (COL_W + 1)'(COLS));

    assign w_rd.load = (r_state == S_ROW);
    assign w_rd.row  = r_rd_row;
    assign w_rd.col  = r_rd_col;

    tt_grid #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (r_cmd),
        .i_rd    (w_rd),
        .o_char  (w_grid_char)
    );

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_cell_char    = r_cell_char;
    assign o_read_valid   = r_read_valid;
    assign o_cursor_row   = r_row;
    assign o_cursor_col   = r_col;
    assign o_scrolled     = r_scrolled;
    assign o_char_count   = r_wcnt;
    assign o_scroll_count = r_scnt;

endmodule

/* hdl/tt_cell.sv */
// tt_cell: one byte cell of the terminal grid
// depends on tt_pkg; takes the byte of the cell below on a scroll, a write wins
module tt_cell import tt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic              i_wr,
    input  logic [CHAR_W-1:0] i_wr_data,
    input  logic [CHAR_W-1:0] i_below,
    output logic [CHAR_W-1:0] o_data
);

    logic [CHAR_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_wr) begin
            r_data <= i_wr_data;
        end else if (i_shift) begin
            r_data <= i_below;
        end
    end

    assign o_data = r_data;

endmodule

/* hdl/tt_grid.sv */
// tt_grid: ROWS x COLS array of tt_cell chained bottom to top, plus read select
// depends on tt_pkg and tt_cell
module tt_grid import tt_pkg::*; #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_grid_cmd         i_cmd,
    input  t_grid_rd          i_rd,
    output logic [CHAR_W-1:0] o_char
);

    logic [CHAR_W-1:0] w_cell   [ROWS][COLS];
    logic [CHAR_W-1:0] r_rowsel [COLS];
    logic [CHAR_W-1:0] n_rowsel [COLS];

    for (genvar gr = 0; gr < ROWS; gr++) begin : g_row
        for (genvar gc = 0; gc < COLS; gc++) begin : g_col
            logic              w_wr;
            logic [CHAR_W-1:0] w_below;

            assign w_wr = i_cmd.wr && (i_cmd.row == ROW_W'(gr)) && (i_cmd.col == COL_W'(gc));

            // bottom row fills with blanks on a scroll
            if (gr == ROWS - 1) begin : g_bot
                assign w_below = '0;
            end else begin : g_mid
                assign w_below = w_cell[gr+1][gc];
            end

            tt_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_shift   (i_cmd.scroll),
                .i_wr      (w_wr),
                .i_wr_data (i_cmd.data),
                .i_below   (w_below),
                .o_data    (w_cell[gr][gc])
            );
        end
    end

    // first read stage: one byte per column from the addressed row
    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            n_rowsel[c] = '0;
            for (int r = 0; r < ROWS; r++) begin
                if (i_rd.row == ROW_W'(r)) begin
                    n_rowsel[c] = w_cell[r][c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.load) begin
            r_rowsel <= n_rowsel;
        end
    end

    // second read stage: pick the column
    always_comb begin
        o_char = '0;
        for (int c = 0; c < COLS; c++) begin
            if (i_rd.col == COL_W'(c)) begin
                o_char = r_rowsel[c];
            end
        end
    end

endmodule

/* hdl/tt_chk.sv */
// tt_chk: port-level checks on text_terminal_grid_top, attached by bind
// depends on tt_pkg
module tt_chk import tt_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input logic [CHAR_W-1:0] o_cell_char,
    input logic              o_read_valid,
    input logic [COL_W-1:0]  o_cursor_col,
    input logic              o_scrolled
);

    // each accepted word gives its result strobe after the execute, row and column states
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##4 o_done)
        else $error("result strobe missing after accepted word");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy ##1 !o_done)
        else $error("result strobe longer than one cycle or while busy");

    a_blank_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_read_valid |-> o_cell_char == '0)
        else $error("cell byte not zero without a valid read");

    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_scrolled |-> !o_read_valid && o_cursor_col <= COL_W'(1))
        else $error("scroll left cursor away from start of bottom row");

endmodule

bind text_terminal_grid_top tt_chk u_tt_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_cell_char  (o_cell_char),
    .o_read_valid (o_read_valid),
    .o_cursor_col (o_cursor_col),
    .o_scrolled   (o_scrolled)
);
